### sv/dq_pkg.sv
// shared types and codes for the double-ended queue unit
// request and result payloads, opcodes, status codes, controller/datapath links
// depends on nothing
package dq_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DUMP       = 3'd4
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] data_in;
    } t_request;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] data_out;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic    write_back;
        logic    write_front;
        logic    read_back;
        logic    read_front;
        logic    dump_first;
        logic    dump_next;
        logic    emit_imm;
        t_status imm_status;
        logic    emit_ram;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic dump_end;
    } t_dp_status;

endpackage

### sv/double_ended_queue_unit.sv
// double-ended queue unit: push and pop at either end, dump front to back
// push, refused request or unused opcode: the beat comes from the result register in the
//   cycle after accept; busy stays low so these run one per cycle; a pop's beat passes the
//   storage read register and then the result register; a pop holds busy while it waits on
//   the registered storage read port, a dump holds busy for its whole run, beats back to back
// reset: synchronous, active low; clears indices, count and control, storage is not cleared
module double_ended_queue_unit #(
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dq_pkg::t_request i_request,
    output logic             o_strobe,
    output dq_pkg::t_result  o_result
);

    // command and status between controller and datapath
    dq_pkg::t_dp_cmd    cmd;
    dq_pkg::t_dp_status dp_status;

    // controller: decodes each accepted request, walks the dump run,
    // waits out the storage read latency of a pop
    dq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_opcode (i_request.opcode),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    // datapath: wrap-around front and back indices, element count,
    // storage ram and the result register that drives the beat
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_data_in (i_request.data_in),
        .o_status  (dp_status),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

### sv/dq_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dq_ctrl.sv
// control state machine of the double-ended queue unit
// decodes requests into datapath commands; uses dq_pkg
module dq_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [dq_pkg::OP_W-1:0] i_opcode,
    input  dq_pkg::t_dp_status      i_status,
    output dq_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_opcode)
                        dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
                            o_cmd.emit_imm = 1'b1;
                            if (i_status.full) begin
                                o_cmd.imm_status = dq_pkg::ST_FULL;
                            end else begin
                                o_cmd.imm_status  = dq_pkg::ST_OK;
                                o_cmd.write_back  = (i_opcode == dq_pkg::OP_PUSH_BACK);
                                o_cmd.write_front = (i_opcode == dq_pkg::OP_PUSH_FRONT);
                            end
                        end
                        dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
                            if (i_status.empty) begin
                                o_cmd.emit_imm   = 1'b1;
                                o_cmd.imm_status = dq_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.read_back  = (i_opcode == dq_pkg::OP_POP_BACK);
                                o_cmd.read_front = (i_opcode == dq_pkg::OP_POP_FRONT);
                                n_state          = S_POP;
                            end
                        end
                        dq_pkg::OP_DUMP: begin
                            if (i_status.empty) begin
                                o_cmd.emit_imm   = 1'b1;
                                o_cmd.imm_status = dq_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.dump_first = 1'b1;
                                n_state          = S_DUMP;
                            end
                        end
                        default: begin
                            o_cmd.emit_imm   = 1'b1;
                            o_cmd.imm_status = dq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_POP: begin
                o_cmd.emit_ram = 1'b1;
                n_state        = S_IDLE;
            end
            S_DUMP: begin
                o_cmd.emit_ram = 1'b1;
                if (i_status.dump_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.dump_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

`ifndef SYNTHESIS
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.write_back, o_cmd.write_front, o_cmd.read_back,
                  o_cmd.read_front, o_cmd.dump_first, o_cmd.dump_next}))
        else $error("more than one datapath action in a cycle");
    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_IDLE))
        else $error("pop wait lasted more than one cycle");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(i_start))
        else $error("busy rose without a request");
`endif

endmodule

### sv/dq_datapath.sv
// datapath of the double-ended queue unit: indices, count, storage, result register
// depends on dq_pkg and dq_ram
module dq_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dq_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [dq_pkg::DATA_W-1:0] i_data_in,
    output dq_pkg::t_dp_status               o_status,
    output logic                             o_strobe,
    output dq_pkg::t_result                  o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = dq_pkg::OCC_W;

    logic [IW-1:0]   r_head;
    logic [IW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic [IW-1:0]   r_dump_ptr;
    logic [IW-1:0]   r_left;
    logic            r_last_pend;
    logic            r_strobe;
    dq_pkg::t_result r_result;

    logic [IW-1:0]   n_head;
    logic [IW-1:0]   n_tail;
    logic [CW-1:0]   n_count;

    logic [IW-1:0]   head_prev;
    logic [IW-1:0]   head_next;
    logic [IW-1:0]   tail_prev;
    logic [IW-1:0]   tail_next;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    logic                      ram_re;
    logic [IW-1:0]             ram_raddr;
    logic [dq_pkg::DATA_W-1:0] ram_rdata;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : IW'(idx + IW'(1));
    endfunction

    function automatic logic [IW-1:0] prev_slot(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(DEPTH - 1) : IW'(idx - IW'(1));
    endfunction

    assign head_prev = prev_slot(r_head);
    assign head_next = next_slot(r_head);
    assign tail_prev = prev_slot(r_tail);
    assign tail_next = next_slot(r_tail);

    assign ram_we    = i_cmd.write_back | i_cmd.write_front;
    assign ram_waddr = i_cmd.write_back ? r_tail : head_prev;
    assign ram_re    = i_cmd.read_back | i_cmd.read_front | i_cmd.dump_first | i_cmd.dump_next;

    always_comb begin
        priority if (i_cmd.read_back) begin
            ram_raddr = tail_prev;
        end else if (i_cmd.dump_next) begin
            ram_raddr = r_dump_ptr;
        end else begin
            ram_raddr = r_head;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.write_back) begin
            n_tail  = tail_next;
            n_count = CW'(r_count + CW'(1));
        end
        if (i_cmd.write_front) begin
            n_head  = head_prev;
            n_count = CW'(r_count + CW'(1));
        end
        if (i_cmd.read_back) begin
            n_tail  = tail_prev;
            n_count = CW'(r_count - CW'(1));
        end
        if (i_cmd.read_front) begin
            n_head  = head_next;
            n_count = CW'(r_count - CW'(1));
        end
    end

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_dump_ptr  <= '0;
            r_left      <= '0;
            r_last_pend <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_strobe <= i_cmd.emit_imm | i_cmd.emit_ram;
            if (i_cmd.dump_first) begin
                r_dump_ptr  <= head_next;
                r_left      <= IW'(r_count - CW'(1));
                r_last_pend <= (r_count == CW'(1));
            end else if (i_cmd.dump_next) begin
                r_dump_ptr  <= next_slot(r_dump_ptr);
                r_left      <= IW'(r_left - IW'(1));
                r_last_pend <= (r_left == IW'(1));
            end else if (i_cmd.read_back | i_cmd.read_front) begin
                r_last_pend <= 1'b1;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_imm) begin
            r_result.status    <= i_cmd.imm_status;
            r_result.data_out  <= '0;
            r_result.occupancy <= OW'(n_count);
            r_result.last      <= 1'b1;
        end else if (i_cmd.emit_ram) begin
            r_result.status    <= dq_pkg::ST_OK;
            r_result.data_out  <= ram_rdata;
            r_result.occupancy <= OW'(r_count);
            r_result.last      <= r_last_pend;
        end
    end

    assign o_status.empty    = (r_count == '0);
    assign o_status.full     = (r_count == CW'(DEPTH));
    assign o_status.dump_end = (r_left == '0);
    assign o_strobe          = r_strobe;
    assign o_result          = r_result;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");
    a_ends_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail apart on an empty or full store");
    a_dump_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_result.last) |=> r_strobe)
        else $error("dump run broken before its last beat");
`endif

endmodule
